// ----- rtl/cphc_pkg.sv -----
// shared types, constants and helpers for the convex polygon half-plane clipper
// no dependencies; cphc_dp, cphc_ctrl and the top level import this package
package cphc_pkg;

    localparam int MAX_VERTS  = 64;
    localparam int RAM_DEPTH  = 2 * MAX_VERTS;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int CNT_W      = 7;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 64;
    localparam int COEF_C_W   = 64;
    localparam int S_W        = 66;
    localparam int MAG_W      = 65;
    localparam int DEN_W      = 66;
    localparam int NUM_W      = 98;
    localparam int QMAG_W     = 97;
    localparam int AREA_ACC_W = 72;
    localparam int AREA_W     = 63;
    localparam int EPS_W      = 32;
    localparam int STEP_W     = $clog2(QMAG_W);
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] KIND_BOX  = 2'd0;
    localparam logic [1:0] KIND_CLIP = 2'd1;
    localparam logic [1:0] KIND_EMIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_EPS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH = 2'd2;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [COORD_W-1:0]  coef_a;
        logic signed [COORD_W-1:0]  coef_b;
        logic signed [COEF_C_W-1:0] coef_c;
    } cphc_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic [CNT_W-1:0]          vertex_count;
        logic [AREA_W-1:0]         area;
        logic                      area_empty;
        logic                      overflow;
        logic                      last;
    } cphc_out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_BOX, ST_RD, ST_LATCH, ST_SMUL_A, ST_SMUL_B, ST_SSUM, ST_EVAL,
        ST_CSETUP, ST_TERM1, ST_CSETUP2, ST_TERM2, ST_DSETUP, ST_DIV, ST_DDONE,
        ST_WRITE, ST_SHIFT, ST_CLIP_OUT, ST_AMUL1, ST_AMUL2, ST_AACC, ST_AFIN,
        ST_EMIT_OUT, ST_EMPTY_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_CLIP, PH_AREA, PH_EMIT
    } phase_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_TAKE, DP_LATCH, DP_SMUL_A, DP_SMUL_B, DP_SSUM, DP_SHIFT,
        DP_CSETUP, DP_TERM1, DP_CSETUP2, DP_TERM2, DP_DSETUP, DP_DIV, DP_DDONE,
        DP_AMUL1, DP_AMUL2, DP_AACC, DP_AFIN
    } dp_op_t;

    typedef enum logic [1:0] {
        WR_BOX, WR_CUR, WR_CUT
    } wr_sel_t;

    typedef enum logic [1:0] {
        OUT_CLIP, OUT_VERT, OUT_EMPTY
    } out_sel_t;

    typedef struct packed {
        dp_op_t            op;
        logic              edge_sel;
        logic              coord_sel;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        wr_sel_t           wr_sel;
        logic [1:0]        corner;
        logic              out_load;
        out_sel_t          out_sel;
        logic              out_last;
        logic [CNT_W-1:0]  out_count;
        logic              out_ovf;
    } dp_cmd_t;

    typedef struct packed {
        logic in_half;
        logic pcut;
        logic ncut;
        logic out_free;
    } dp_stat_t;

    function automatic logic [ADDR_W-1:0] bank_addr(input logic bank,
                                                    input logic [CNT_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(MAX_VERTS) : '0;
        return base + ADDR_W'(idx);
    endfunction

endpackage

// ----- rtl/cphc_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module cphc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/cphc_dp.sv -----
// datapath: config registers, vertex rams, side values, cut arithmetic,
// area accumulator and result register; uses cphc_pkg and cphc_ram
module cphc_dp
    import cphc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cphc_in_t             item,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EPS_W-1:0]     cfg_data,
    input  logic                 result_stall,
    output logic                 result_valid,
    output cphc_out_t            result,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    logic [EPS_W-1:0]          eps_reg;
    logic signed [COORD_W-1:0] box_low_reg, box_high_reg;
    logic signed [COORD_W-1:0] a_reg, b_reg;
    logic signed [COEF_C_W-1:0] c_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg, cx_reg, cy_reg, nx_reg, ny_reg;
    logic signed [S_W-1:0]     ps_reg, cs_reg, ns_reg, sacc_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic [MAG_W-1:0]          u_reg, v_reg;
    logic signed [COORD_W-1:0] x1_reg, x2_reg;
    logic [COORD_W-1:0]        mag_reg;
    logic [NUM_W-1:0]          w_reg;
    logic                      neg_reg;
    logic signed [NUM_W-1:0]   acc_reg;
    logic                      numneg_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [DEN_W:0]            rem_reg;
    logic [QMAG_W-1:0]         quo_reg;
    logic signed [COORD_W-1:0] rx_reg, ry_reg;

    logic signed [AREA_ACC_W-1:0] aacc_reg;
    logic [AREA_W-1:0]            area_reg;

    logic      out_valid_reg;
    cphc_out_t out_reg;

    logic signed [COORD_W-1:0] rd_x, rd_y, wr_x, wr_y;
    logic signed [COORD_W-1:0] ma, mb;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [S_W-1:0]     prod_ext, eps_s, neps_s, s_first, s_second;
    logic signed [COORD_W-1:0] fx, sx;
    logic [MAG_W-1:0]          first_mag, second_mag;
    logic [NUM_W-1:0]          acc_mag;
    logic [DEN_W:0]            rem_sh;
    logic [COORD_W-1:0]        q_lo;
    logic signed [COORD_W-1:0] cut_res;
    logic [AREA_ACC_W-1:0]     aacc_mag, aacc_half;

    cphc_ram #(.WIDTH(COORD_W), .DEPTH(RAM_DEPTH)) u_ram_x (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_x),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_x)
    );

    cphc_ram #(.WIDTH(COORD_W), .DEPTH(RAM_DEPTH)) u_ram_y (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_y),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_y)
    );

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_BOX:
            begin
                wr_x = (cmd.corner == 2'd1 || cmd.corner == 2'd2) ? box_high_reg : box_low_reg;
                wr_y = (cmd.corner == 2'd2 || cmd.corner == 2'd3) ? box_high_reg : box_low_reg;
            end
            WR_CUR:
            begin
                wr_x = cx_reg;
                wr_y = cy_reg;
            end
            default:
            begin
                wr_x = rx_reg;
                wr_y = ry_reg;
            end
        endcase
    end

    // one shared signed multiplier for side values and the shoelace sum
    always_comb
    begin
        unique case (cmd.op)
            DP_SMUL_B:
            begin
                ma = b_reg;
                mb = ny_reg;
            end
            DP_AMUL1:
            begin
                ma = cx_reg;
                mb = ny_reg;
            end
            DP_AMUL2:
            begin
                ma = cy_reg;
                mb = nx_reg;
            end
            default:
            begin
                ma = a_reg;
                mb = nx_reg;
            end
        endcase
        prod_next = ma * mb;
    end

    assign prod_ext = {{(S_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign eps_s    = {{(S_W-EPS_W){1'b0}}, eps_reg};
    assign neps_s   = -eps_s;

    assign stat.in_half  = cs_reg < eps_s;
    assign stat.pcut     = ps_reg < neps_s;
    assign stat.ncut     = ns_reg < neps_s;
    assign stat.out_free = !out_valid_reg || !result_stall;

    // edge endpoints: prev->cur or cur->next
    always_comb
    begin
        s_first  = cmd.edge_sel ? cs_reg : ps_reg;
        s_second = cmd.edge_sel ? ns_reg : cs_reg;
        if (cmd.edge_sel)
        begin
            fx = cmd.coord_sel ? cy_reg : cx_reg;
            sx = cmd.coord_sel ? ny_reg : nx_reg;
        end
        else
        begin
            fx = cmd.coord_sel ? py_reg : px_reg;
            sx = cmd.coord_sel ? cy_reg : cx_reg;
        end
        first_mag  = s_first[S_W-1] ? MAG_W'(-s_first) : MAG_W'(s_first);
        second_mag = s_second[S_W-1] ? MAG_W'(-s_second) : MAG_W'(s_second);
    end

    assign acc_mag = acc_reg[NUM_W-1] ? NUM_W'(-acc_reg) : NUM_W'(acc_reg);
    assign rem_sh  = {rem_reg[DEN_W-1:0], quo_reg[QMAG_W-1]};
    assign q_lo    = quo_reg[COORD_W-1:0];

    always_comb
    begin
        if (den_reg == '0)
        begin
            cut_res = x1_reg;
        end
        else if (numneg_reg)
        begin
            cut_res = -q_lo;
        end
        else
        begin
            cut_res = q_lo;
        end
    end

    assign aacc_mag  = aacc_reg[AREA_ACC_W-1] ? AREA_ACC_W'(-aacc_reg)
                                               : AREA_ACC_W'(aacc_reg);
    assign aacc_half = aacc_mag >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg       <= '0;
            box_low_reg   <= '0;
            box_high_reg  <= 32'h7FFF_FFFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_EPS:      eps_reg      <= cfg_data;
                    CFG_BOX_LOW:  box_low_reg  <= cfg_data;
                    CFG_BOX_HIGH: box_high_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_TAKE:
            begin
                a_reg    <= item.coef_a;
                b_reg    <= item.coef_b;
                c_reg    <= item.coef_c;
                aacc_reg <= '0;
            end
            DP_LATCH:
            begin
                nx_reg <= rd_x;
                ny_reg <= rd_y;
            end
            DP_SMUL_A:
            begin
                prod_reg <= prod_next;
            end
            DP_SMUL_B:
            begin
                prod_reg <= prod_next;
                sacc_reg <= {{(S_W-COEF_C_W){c_reg[COEF_C_W-1]}}, c_reg} + prod_ext;
            end
            DP_SSUM:
            begin
                ns_reg <= sacc_reg + prod_ext;
            end
            DP_SHIFT:
            begin
                px_reg <= cx_reg;
                py_reg <= cy_reg;
                ps_reg <= cs_reg;
                cx_reg <= nx_reg;
                cy_reg <= ny_reg;
                cs_reg <= ns_reg;
            end
            DP_CSETUP:
            begin
                u_reg   <= first_mag;
                v_reg   <= second_mag;
                x1_reg  <= fx;
                x2_reg  <= sx;
                mag_reg <= fx[COORD_W-1] ? -fx : fx;
                w_reg   <= NUM_W'(second_mag);
                neg_reg <= fx[COORD_W-1];
                acc_reg <= '0;
            end
            DP_TERM1, DP_TERM2:
            begin
                // shift-add multiply of a coordinate magnitude by a side weight
                if (mag_reg[0])
                begin
                    acc_reg <= neg_reg ? acc_reg - w_reg : acc_reg + w_reg;
                end
                mag_reg <= mag_reg >> 1;
                w_reg   <= w_reg << 1;
            end
            DP_CSETUP2:
            begin
                mag_reg <= x2_reg[COORD_W-1] ? -x2_reg : x2_reg;
                w_reg   <= NUM_W'(u_reg);
                neg_reg <= x2_reg[COORD_W-1];
            end
            DP_DSETUP:
            begin
                numneg_reg <= acc_reg[NUM_W-1];
                quo_reg    <= acc_mag[QMAG_W-1:0];
                rem_reg    <= '0;
                den_reg    <= DEN_W'(u_reg) + DEN_W'(v_reg);
            end
            DP_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    quo_reg <= {quo_reg[QMAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[QMAG_W-2:0], 1'b0};
                end
            end
            DP_DDONE:
            begin
                if (cmd.coord_sel)
                begin
                    ry_reg <= cut_res;
                end
                else
                begin
                    rx_reg <= cut_res;
                end
            end
            DP_AMUL1:
            begin
                prod_reg <= prod_next;
            end
            DP_AMUL2:
            begin
                prod_reg <= prod_next;
                aacc_reg <= aacc_reg + {{(AREA_ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
            DP_AACC:
            begin
                aacc_reg <= aacc_reg - {{(AREA_ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
            DP_AFIN:
            begin
                // saturate the halved magnitude to the 63-bit range
                area_reg <= (aacc_half[AREA_ACC_W-1:AREA_W] != '0) ? '1
                                                                   : aacc_half[AREA_W-1:0];
            end
            default: ;
        endcase

        if (cmd.out_load)
        begin
            out_reg.vertex_count <= cmd.out_count;
            out_reg.overflow     <= cmd.out_ovf;
            out_reg.last         <= cmd.out_last;
            unique case (cmd.out_sel)
                OUT_VERT:
                begin
                    out_reg.vertex_x   <= nx_reg;
                    out_reg.vertex_y   <= ny_reg;
                    out_reg.area       <= cmd.out_last ? area_reg : '0;
                    out_reg.area_empty <= cmd.out_last && (area_reg < AREA_W'(eps_reg));
                end
                OUT_EMPTY:
                begin
                    out_reg.vertex_x   <= '0;
                    out_reg.vertex_y   <= '0;
                    out_reg.area       <= '0;
                    out_reg.area_empty <= 1'b1;
                end
                default:
                begin
                    out_reg.vertex_x   <= '0;
                    out_reg.vertex_y   <= '0;
                    out_reg.area       <= '0;
                    out_reg.area_empty <= 1'b0;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/cphc_ctrl.sv -----
// controller: state machine, vertex counters, polygon count, bank and overflow flag
// uses cphc_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t
module cphc_ctrl
    import cphc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] item_kind,
    output logic       item_stall,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       pre_reg, pre_next;
    logic [1:0]       k_reg, k_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic             bank_reg, bank_next;
    logic             ovf_reg, ovf_next;
    logic             edge_reg, edge_next;
    logic             coord_reg, coord_next;
    logic             ncut_reg, ncut_next;
    logic             wcut_reg, wcut_next;

    logic             take;
    logic             i_last;
    logic             room;
    logic [CNT_W-1:0] load_idx;

    assign take   = (state_reg == ST_IDLE) && item_valid;
    assign i_last = (i_reg + 1'b1) == n_reg;
    assign room   = cnt_reg < CNT_W'(MAX_VERTS);

    // clip preload phases fetch the last vertex then the first one; an emit preloads only the first
    always_comb
    begin
        if (phase_reg == PH_EMIT)
        begin
            load_idx = i_reg;
        end
        else if (pre_reg == 2'd0)
        begin
            load_idx = n_reg - 1'b1;
        end
        else if (pre_reg == 2'd1 || i_last)
        begin
            load_idx = '0;
        end
        else
        begin
            load_idx = i_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item_kind)
                        KIND_BOX:  state_next = ST_BOX;
                        KIND_CLIP: state_next = (n_reg == '0) ? ST_CLIP_OUT : ST_RD;
                        KIND_EMIT: state_next = (n_reg == '0) ? ST_EMPTY_OUT : ST_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BOX:      state_next = (k_reg == 2'd3) ? ST_IDLE : ST_BOX;
            ST_RD:       state_next = ST_LATCH;
            ST_LATCH:
            begin
                unique case (phase_reg)
                    PH_CLIP: state_next = ST_SMUL_A;
                    PH_AREA: state_next = (pre_reg != 2'd2) ? ST_SHIFT : ST_AMUL1;
                    default: state_next = ST_EMIT_OUT;
                endcase
            end
            ST_SMUL_A:   state_next = ST_SMUL_B;
            ST_SMUL_B:   state_next = ST_SSUM;
            ST_SSUM:     state_next = (pre_reg != 2'd2) ? ST_SHIFT : ST_EVAL;
            ST_EVAL:
            begin
                priority if (stat.in_half)
                    state_next = ST_WRITE;
                else if (stat.pcut || stat.ncut)
                    state_next = ST_CSETUP;
                else
                    state_next = ST_SHIFT;
            end
            ST_CSETUP:   state_next = ST_TERM1;
            ST_TERM1:    state_next = (step_reg == STEP_W'(COORD_W-1)) ? ST_CSETUP2 : ST_TERM1;
            ST_CSETUP2:  state_next = ST_TERM2;
            ST_TERM2:    state_next = (step_reg == STEP_W'(COORD_W-1)) ? ST_DSETUP : ST_TERM2;
            ST_DSETUP:   state_next = ST_DIV;
            ST_DIV:      state_next = (step_reg == STEP_W'(QMAG_W-1)) ? ST_DDONE : ST_DIV;
            ST_DDONE:    state_next = coord_reg ? ST_WRITE : ST_CSETUP;
            ST_WRITE:
            begin
                state_next = (wcut_reg && !edge_reg && ncut_reg) ? ST_CSETUP : ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (pre_reg != 2'd2 || !i_last)
                    state_next = ST_RD;
                else
                    state_next = (phase_reg == PH_CLIP) ? ST_CLIP_OUT : ST_AFIN;
            end
            ST_CLIP_OUT: state_next = stat.out_free ? ST_IDLE : ST_CLIP_OUT;
            ST_AMUL1:    state_next = ST_AMUL2;
            ST_AMUL2:    state_next = ST_AACC;
            ST_AACC:     state_next = ST_SHIFT;
            ST_AFIN:     state_next = ST_RD;
            ST_EMIT_OUT:
            begin
                if (stat.out_free)
                    state_next = i_last ? ST_IDLE : ST_RD;
            end
            ST_EMPTY_OUT: state_next = stat.out_free ? ST_IDLE : ST_EMPTY_OUT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // counters and architectural state
    always_comb
    begin
        phase_next = phase_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        cnt_next   = cnt_reg;
        pre_next   = pre_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        bank_next  = bank_reg;
        ovf_next   = ovf_reg;
        edge_next  = edge_reg;
        coord_next = coord_reg;
        ncut_next  = ncut_reg;
        wcut_next  = wcut_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next   = '0;
                cnt_next = '0;
                i_next   = '0;
                if (item_kind == KIND_EMIT)
                begin
                    phase_next = PH_AREA;
                    pre_next   = 2'd1;
                end
                else
                begin
                    phase_next = PH_CLIP;
                    pre_next   = 2'd0;
                end
            end
            ST_BOX:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    n_next   = CNT_W'(4);
                    ovf_next = 1'b0;
                end
            end
            ST_EVAL:
            begin
                coord_next = 1'b0;
                wcut_next  = !stat.in_half;
                edge_next  = !stat.pcut;
                ncut_next  = stat.pcut && stat.ncut;
            end
            ST_CSETUP, ST_CSETUP2, ST_DSETUP:
            begin
                step_next = '0;
            end
            ST_TERM1, ST_TERM2, ST_DIV:
            begin
                step_next = step_reg + 1'b1;
            end
            ST_DDONE:
            begin
                coord_next = 1'b1;
            end
            ST_WRITE:
            begin
                if (room)
                    cnt_next = cnt_reg + 1'b1;
                else
                    ovf_next = 1'b1;
                if (wcut_reg && !edge_reg && ncut_reg)
                begin
                    edge_next  = 1'b1;
                    coord_next = 1'b0;
                end
            end
            ST_SHIFT:
            begin
                if (pre_reg != 2'd2)
                    pre_next = pre_reg + 1'b1;
                else if (!i_last)
                    i_next = i_reg + 1'b1;
            end
            ST_CLIP_OUT:
            begin
                if (stat.out_free)
                begin
                    n_next    = cnt_reg;
                    bank_next = !bank_reg;
                end
            end
            ST_AFIN:
            begin
                phase_next = PH_EMIT;
                i_next     = '0;
            end
            ST_EMIT_OUT:
            begin
                if (stat.out_free && !i_last)
                    i_next = i_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.edge_sel  = edge_reg;
        cmd.coord_sel = coord_reg;
        cmd.rd_addr   = bank_addr(bank_reg, load_idx);
        cmd.corner    = k_reg;
        cmd.out_count = n_reg;
        cmd.out_ovf   = ovf_reg;
        item_stall    = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    cmd.op = DP_TAKE;
            end
            ST_BOX:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = bank_addr(bank_reg, CNT_W'(k_reg));
                cmd.wr_sel  = WR_BOX;
            end
            ST_LATCH:   cmd.op = DP_LATCH;
            ST_SMUL_A:  cmd.op = DP_SMUL_A;
            ST_SMUL_B:  cmd.op = DP_SMUL_B;
            ST_SSUM:    cmd.op = DP_SSUM;
            ST_CSETUP:  cmd.op = DP_CSETUP;
            ST_TERM1:   cmd.op = DP_TERM1;
            ST_CSETUP2: cmd.op = DP_CSETUP2;
            ST_TERM2:   cmd.op = DP_TERM2;
            ST_DSETUP:  cmd.op = DP_DSETUP;
            ST_DIV:     cmd.op = DP_DIV;
            ST_DDONE:   cmd.op = DP_DDONE;
            ST_WRITE:
            begin
                cmd.wr_en   = room;
                cmd.wr_addr = bank_addr(!bank_reg, cnt_reg);
                cmd.wr_sel  = wcut_reg ? WR_CUT : WR_CUR;
            end
            ST_SHIFT:   cmd.op = DP_SHIFT;
            ST_CLIP_OUT:
            begin
                cmd.out_load  = stat.out_free;
                cmd.out_sel   = OUT_CLIP;
                cmd.out_last  = 1'b1;
                cmd.out_count = cnt_reg;
            end
            ST_AMUL1:   cmd.op = DP_AMUL1;
            ST_AMUL2:   cmd.op = DP_AMUL2;
            ST_AACC:    cmd.op = DP_AACC;
            ST_AFIN:    cmd.op = DP_AFIN;
            ST_EMIT_OUT:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_sel  = OUT_VERT;
                cmd.out_last = i_last;
            end
            ST_EMPTY_OUT:
            begin
                cmd.out_load  = stat.out_free;
                cmd.out_sel   = OUT_EMPTY;
                cmd.out_last  = 1'b1;
                cmd.out_count = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_CLIP;
            n_reg     <= '0;
            i_reg     <= '0;
            cnt_reg   <= '0;
            pre_reg   <= '0;
            k_reg     <= '0;
            step_reg  <= '0;
            bank_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            edge_reg  <= 1'b0;
            coord_reg <= 1'b0;
            ncut_reg  <= 1'b0;
            wcut_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            cnt_reg   <= cnt_next;
            pre_reg   <= pre_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            bank_reg  <= bank_next;
            ovf_reg   <= ovf_next;
            edge_reg  <= edge_next;
            coord_reg <= coord_next;
            ncut_reg  <= ncut_next;
            wcut_reg  <= wcut_next;
        end
    end

endmodule

// ----- rtl/convex_polygon_halfplane_clip.sv -----
// top level of the convex polygon half-plane clipper
// uses cphc_pkg, instantiates cphc_ctrl and cphc_dp
//
// Holds one convex polygon (up to 64 Q16.16 vertices) in two ping-pong banks
// of a pair of vertex rams and takes one item at a time. A box load writes
// the four corners. A clip walks the stored polygon once: it preloads the
// window, then evaluates each vertex and writes or drops it, and computes
// every edge intersection with the 32-step shift-add weighting and the
// 97-step restoring divider run for each coordinate; one result follows. An
// emit makes a shoelace pass through the single shared multiplier, then
// sends each vertex, and waits whenever the result register is stalled. The
// config channel is always ready.
module convex_polygon_halfplane_clip
    import cphc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  cphc_in_t             item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output cphc_out_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EPS_W-1:0]     cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    cphc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    cphc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
